// File: rtl/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, codes and saturation helpers for the skinning core.
// ----------------------------------------------------------------------------
package lbs_pkg;

	localparam int MAX_JOINTS_DEF = 256;
	localparam int ELEM_BITS = 4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_INFL = 1'b1;

	localparam logic REG_NORMALS = 1'b0;
	localparam logic REG_JOINTS = 1'b1;

	localparam logic [16:0] W_ONE = 17'd65536;

	typedef struct packed {
		logic cmd;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] nrm_x;
		logic signed [15:0] nrm_y;
		logic signed [15:0] nrm_z;
		logic [7:0] joint;
		logic [16:0] weight;
		logic last_influence;
		logic [3:0] elem;
		logic signed [31:0] mat_value;
	} lbs_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [15:0] out_nx;
		logic signed [15:0] out_ny;
		logic signed [15:0] out_nz;
		logic bad_joint;
	} lbs_out_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic err_set;
		logic [1:0] col;
		logic [1:0] row;
		logic sum_clr;
		logic sum_add;
		logic sum_trans;
		logic wmul;
		logic upd;
		logic norm_start;
		logic emit;
	} lbs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic w_zero;
		logic joint_ok;
		logic last;
		logic norm_done;
	} lbs_stat_t;

	function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
		if (v[50:47] == {4{v[47]}})
			return v[47:0];
		return v[50] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
		if (v[40] == v[39])
			return v[39:0];
		return v[40] ? {1'b1, {39{1'b0}}} : {1'b0, {39{1'b1}}};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v[47:31] == {17{v[31]}})
			return v[31:0];
		return v[47] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
	endfunction

endpackage

// File: rtl/linear_blend_skinning_core.sv
// ----------------------------------------------------------------------------
// linear_blend_skinning_core
// Linear blend skinning with a 4x4 matrix palette and APB configuration.
// ----------------------------------------------------------------------------
// A load transaction writes one palette word. An influence with zero weight
// or a joint at or above the configured joint count skips the row passes;
// any other influence is paced by the single palette read port feeding the
// matrix multipliers one word per cycle over three eight-step row passes. The
// final influence of a vertex then passes a finish state, with normals
// enabled a renormalization (prescale, three squares, a 32-step square root,
// three bit-serial divisions and a handoff), and an emit state that loads the
// result register. A finished result waits in its output register while the
// next transaction is taken.
module linear_blend_skinning_core import lbs_pkg::*; #(
	parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic item_valid,
	output logic item_ready,
	input lbs_in_t item,
	output logic result_valid,
	input logic result_ready,
	output lbs_out_t result
);

	logic normals_q;
	logic [8:0] joint_count_q;
	logic cfg_wr;
	lbs_cmd_t cmd;
	lbs_stat_t stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_NORMALS) ? {31'd0, normals_q} : {23'd0, joint_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normals_q <= 1'b0;
			joint_count_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_NORMALS: normals_q <= pwdata[0];
				REG_JOINTS: joint_count_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	lbs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_cmd(item.cmd),
		.item_ready(item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.normals_en(normals_q),
		.stat(stat),
		.cmd(cmd)
	);

	lbs_dp #(
		.MAX_JOINTS(MAX_JOINTS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cmd(cmd),
		.normals_en(normals_q),
		.joint_count(joint_count_q),
		.stat(stat),
		.result(result)
	);

endmodule

// File: rtl/lbs_norm.sv
// ----------------------------------------------------------------------------
// lbs_norm
// Normal renormalization: magnitude prescale, sum of squares, bit-serial
// square root and three bit-serial divisions to unit length in Q1.14.
// ----------------------------------------------------------------------------
module lbs_norm import lbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [39:0] acc [3],
	output logic signed [15:0] nrm [3],
	output logic done
);

	localparam logic [2:0] NS_IDLE = 3'd0;
	localparam logic [2:0] NS_SHIFT = 3'd1;
	localparam logic [2:0] NS_SQ = 3'd2;
	localparam logic [2:0] NS_ROOT = 3'd3;
	localparam logic [2:0] NS_DLOAD = 3'd4;
	localparam logic [2:0] NS_DRUN = 3'd5;

	logic [2:0] state_q;
	logic [1:0] idx_q;
	logic [3:0] cnt_q;
	logic done_q;

	logic [39:0] mag_q [3];
	logic neg_q [3];
	logic [61:0] sq_q;
	logic [61:0] rv_q;
	logic [62:0] rr_q;
	logic [62:0] bit_q;
	logic [30:0] len_q;
	logic [31:0] rem_q;
	logic [14:0] numlo_q;
	logic [14:0] quo_q;

	logic [29:0] mag_sel;
	logic [59:0] sq_prod;
	logic [61:0] sq_next;
	logic [62:0] trial;
	logic root_take;
	logic [62:0] rr_next;
	logic [44:0] num;
	logic [31:0] rem_sh;
	logic rem_ge;
	logic [14:0] quo_next;
	logic [14:0] quo_clip;
	logic any_big;

	assign mag_sel = mag_q[idx_q][29:0];
	assign sq_prod = mag_sel * mag_sel;
	assign sq_next = sq_q + {2'd0, sq_prod};

	assign trial = rr_q + bit_q;
	assign root_take = ({1'b0, rv_q} >= trial);
	assign rr_next = root_take ? ((rr_q >> 1) + bit_q) : (rr_q >> 1);

	assign num = {1'b0, mag_sel, 14'd0} + {15'd0, len_q[30:1]};
	assign rem_sh = {rem_q[30:0], numlo_q[14]};
	assign rem_ge = (rem_sh >= {1'b0, len_q});
	assign quo_next = {quo_q[13:0], rem_ge};
	assign quo_clip = (quo_next > 15'd16384) ? 15'd16384 : quo_next;

	assign any_big = (mag_q[0][39:30] != '0) || (mag_q[1][39:30] != '0) ||
		(mag_q[2][39:30] != '0);

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= NS_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				NS_IDLE: begin
					if (start)
						state_q <= NS_SHIFT;
				end
				NS_SHIFT: begin
					if (!any_big)
						state_q <= NS_SQ;
				end
				NS_SQ: begin
					if (idx_q == 2'd2)
						state_q <= NS_ROOT;
				end
				NS_ROOT: begin
					if (bit_q[0])
						state_q <= NS_DLOAD;
				end
				NS_DLOAD: begin
					if (len_q == '0) begin
						if (idx_q == 2'd2) begin
							state_q <= NS_IDLE;
							done_q <= 1'b1;
						end
					end else begin
						state_q <= NS_DRUN;
					end
				end
				NS_DRUN: begin
					if (cnt_q == '0) begin
						if (idx_q == 2'd2) begin
							state_q <= NS_IDLE;
							done_q <= 1'b1;
						end else begin
							state_q <= NS_DLOAD;
						end
					end
				end
				default: state_q <= NS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			NS_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= acc[i][39];
						mag_q[i] <= acc[i][39] ? 40'(-acc[i]) : 40'(acc[i]);
					end
				end
			end
			NS_SHIFT: begin
				// scale all three together until each fits 30 bits
				if (any_big) begin
					for (int i = 0; i < 3; i++)
						mag_q[i] <= mag_q[i] >> 1;
				end else begin
					idx_q <= 2'd0;
					sq_q <= '0;
				end
			end
			NS_SQ: begin
				sq_q <= sq_next;
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd2) begin
					rv_q <= sq_next;
					rr_q <= '0;
					bit_q <= {1'b1, 62'd0};
				end
			end
			NS_ROOT: begin
				if (root_take)
					rv_q <= rv_q - trial[61:0];
				rr_q <= rr_next;
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					len_q <= rr_next[30:0];
					idx_q <= 2'd0;
				end
			end
			NS_DLOAD: begin
				rem_q <= {2'd0, num[44:15]};
				numlo_q <= num[14:0];
				quo_q <= '0;
				cnt_q <= 4'd14;
				if (len_q == '0) begin
					nrm[idx_q] <= '0;
					idx_q <= idx_q + 2'd1;
				end
			end
			NS_DRUN: begin
				rem_q <= rem_ge ? (rem_sh - {1'b0, len_q}) : rem_sh;
				numlo_q <= {numlo_q[13:0], 1'b0};
				quo_q <= quo_next;
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == '0) begin
					nrm[idx_q] <= neg_q[idx_q] ? 16'(-{1'b0, quo_clip}) : {1'b0, quo_clip};
					idx_q <= idx_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/lbs_dp.sv
// ----------------------------------------------------------------------------
// lbs_dp
// Skinning datapath: matrix palette, matrix and weight multipliers,
// row sums, blend accumulators, error flag and the result register.
// ----------------------------------------------------------------------------
module lbs_dp import lbs_pkg::*; #(
	parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input lbs_in_t item,
	input lbs_cmd_t cmd,
	input logic normals_en,
	input logic [8:0] joint_count,
	output lbs_stat_t stat,
	output lbs_out_t result
);

	localparam int PAL_JOINTS = (MAX_JOINTS < 256) ? MAX_JOINTS : 256;
	localparam int JW = (PAL_JOINTS > 1) ? $clog2(PAL_JOINTS) : 1;
	localparam int PAL_DEPTH = PAL_JOINTS * (2 ** ELEM_BITS);

	logic signed [31:0] pal_mem [PAL_DEPTH];

	lbs_in_t item_q;
	logic [16:0] w_q;
	logic signed [31:0] md_q;
	logic [1:0] col_s1;
	logic signed [63:0] pprod_s2;
	logic signed [47:0] nprod_s2;
	logic signed [31:0] md_s2;
	logic signed [49:0] tsum_q;
	logic signed [49:0] qsum_q;
	logic signed [65:0] wp_s3;
	logic signed [51:0] wn_s3;
	logic signed [47:0] pos_acc_q [3];
	logic signed [39:0] nrm_acc_q [3];
	logic err_q;

	logic ld_ok;
	logic max_ok;
	logic [JW+ELEM_BITS-1:0] rd_addr;
	logic signed [31:0] popnd;
	logic signed [15:0] nopnd;
	logic signed [17:0] w18;
	logic signed [47:0] t48;
	logic signed [33:0] n34;
	logic signed [15:0] nrm_res [3];
	logic norm_done;

	assign ld_ok = ({24'd0, item.joint} < 32'(MAX_JOINTS));
	assign max_ok = ({24'd0, item_q.joint} < 32'(MAX_JOINTS));
	assign rd_addr = {item_q.joint[JW-1:0], cmd.col, cmd.row};

	assign stat.w_zero = (w_q == '0);
	assign stat.joint_ok = ({1'b0, item_q.joint} < joint_count) && max_ok;
	assign stat.last = item_q.last_influence;
	assign stat.norm_done = norm_done;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= item;
			w_q <= (item.weight > W_ONE) ? W_ONE : item.weight;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && item.cmd == CMD_LOAD && ld_ok)
			pal_mem[{item.joint[JW-1:0], item.elem}] <= item.mat_value;
		md_q <= pal_mem[rd_addr];
	end

	always_comb begin
		case (col_s1)
			2'd0: begin
				popnd = item_q.pos_x;
				nopnd = item_q.nrm_x;
			end
			2'd1: begin
				popnd = item_q.pos_y;
				nopnd = item_q.nrm_y;
			end
			default: begin
				popnd = item_q.pos_z;
				nopnd = item_q.nrm_z;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		col_s1 <= cmd.col;
		pprod_s2 <= popnd * md_q;
		nprod_s2 <= nopnd * md_q;
		md_s2 <= md_q;
	end

	// row sums: floored position terms plus translation, raw normal terms
	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			tsum_q <= '0;
			qsum_q <= '0;
		end else if (cmd.sum_add) begin
			tsum_q <= tsum_q + {{2{pprod_s2[63]}}, pprod_s2[63:16]};
			qsum_q <= qsum_q + {{2{nprod_s2[47]}}, nprod_s2};
		end else if (cmd.sum_trans) begin
			tsum_q <= tsum_q + {{18{md_s2[31]}}, md_s2};
		end
	end

	assign w18 = $signed({1'b0, w_q});
	assign t48 = sat48({tsum_q[49], tsum_q});
	assign n34 = qsum_q[49:16];

	always_ff @(posedge clk) begin
		if (cmd.wmul) begin
			wp_s3 <= t48 * w18;
			wn_s3 <= n34 * w18;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_acc_q[i] <= '0;
				nrm_acc_q[i] <= '0;
			end
			err_q <= 1'b0;
		end else if (cmd.emit) begin
			for (int i = 0; i < 3; i++) begin
				pos_acc_q[i] <= '0;
				nrm_acc_q[i] <= '0;
			end
			err_q <= 1'b0;
		end else begin
			if (cmd.err_set)
				err_q <= 1'b1;
			if (cmd.upd) begin
				pos_acc_q[cmd.row] <= sat48({{3{pos_acc_q[cmd.row][47]}}, pos_acc_q[cmd.row]} +
					{wp_s3[65], wp_s3[65:16]});
				if (normals_en)
					nrm_acc_q[cmd.row] <= sat40({nrm_acc_q[cmd.row][39], nrm_acc_q[cmd.row]} +
						{{5{wn_s3[51]}}, wn_s3[51:16]});
			end
		end
	end

	lbs_norm u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.norm_start),
		.acc(nrm_acc_q),
		.nrm(nrm_res),
		.done(norm_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result.out_x <= sat32(pos_acc_q[0]);
			result.out_y <= sat32(pos_acc_q[1]);
			result.out_z <= sat32(pos_acc_q[2]);
			result.out_nx <= normals_en ? nrm_res[0] : '0;
			result.out_ny <= normals_en ? nrm_res[1] : '0;
			result.out_nz <= normals_en ? nrm_res[2] : '0;
			result.bad_joint <= err_q;
		end
	end

endmodule

// File: rtl/lbs_ctrl.sv
// ----------------------------------------------------------------------------
// lbs_ctrl
// Sequencer: item decode, three eight-step row passes per influence,
// renormalization handoff and result handshake.
// ----------------------------------------------------------------------------
module lbs_ctrl import lbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_cmd,
	output logic item_ready,
	output logic result_valid,
	input logic result_ready,
	input logic normals_en,
	input lbs_stat_t stat,
	output lbs_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC = 3'd1;
	localparam logic [2:0] S_MAC = 3'd2;
	localparam logic [2:0] S_FIN = 3'd3;
	localparam logic [2:0] S_NWAIT = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0] state_q, state_d;
	logic [1:0] row_q, row_d;
	logic [2:0] step_q, step_d;
	logic out_valid_q;

	assign item_ready = (state_q == S_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.row = row_q;
		cmd.col = step_q[1:0];
		cmd.take = item_valid && item_ready;
		state_d = state_q;
		row_d = row_q;
		step_d = step_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.take && item_cmd == CMD_INFL)
					state_d = S_DEC;
			end
			S_DEC: begin
				if (!stat.w_zero && stat.joint_ok) begin
					state_d = S_MAC;
					row_d = 2'd0;
					step_d = 3'd0;
				end else begin
					cmd.err_set = !stat.w_zero;
					state_d = stat.last ? S_FIN : S_IDLE;
				end
			end
			S_MAC: begin
				// reads on steps 0-3, sums on 2-5, weight on 6, accumulate on 7
				cmd.sum_clr = (step_q == 3'd0);
				cmd.sum_add = (step_q >= 3'd2) && (step_q <= 3'd4);
				cmd.sum_trans = (step_q == 3'd5);
				cmd.wmul = (step_q == 3'd6);
				cmd.upd = (step_q == 3'd7);
				step_d = step_q + 3'd1;
				if (step_q == 3'd7) begin
					if (row_q == 2'd2)
						state_d = stat.last ? S_FIN : S_IDLE;
					else
						row_d = row_q + 2'd1;
				end
			end
			S_FIN: begin
				if (normals_en) begin
					cmd.norm_start = 1'b1;
					state_d = S_NWAIT;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_NWAIT: begin
				if (stat.norm_done)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || result_ready) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q <= '0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q <= row_d;
			step_q <= step_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule
